### hdl/jcst_pkg.sv
// ----------------------------------------------------------------------------
// jcst_pkg
// Shared constants and state types for the joint channel soft threshold block.
// ----------------------------------------------------------------------------
package jcst_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    // register widths
    localparam int THR_BITS       = 17;
    localparam int CIU_BITS       = 4;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS  = 2'd1;

    localparam logic [CIU_BITS-1:0] CIU_RESET = 4'd1;

    // main sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ACC,
        ST_ROOT,
        ST_SC_RE,
        ST_SC_IM,
        ST_SC_FIN,
        ST_OUT
    } jcst_state_t;

    // root / divide engine
    typedef enum logic [2:0] {
        RD_IDLE,
        RD_ROOT,
        RD_CMP,
        RD_DIV,
        RD_DONE
    } jcst_rd_state_t;

endpackage

### hdl/joint_channel_soft_threshold_top.sv
// ----------------------------------------------------------------------------
// joint_channel_soft_threshold_top
// Group soft threshold across coil channels: one complex channel per input
// request, shrunk channels out once a pixel group is complete.
// ----------------------------------------------------------------------------
//
//  channel   signals                              contents (low bit first)
//  -------   ----------------------------------   --------------------------
//  cfg       cfg_valid/cfg_ready/cfg_index/data   0: threshold, 1: channels
//  s_axis    tvalid/tready/tdata                  re_in, im_in
//  m_axis    tvalid/tready/tdata/tlast            re_out, im_out; tlast = last
//
//  Each input request passes through accept, square re, square im and
//  accumulate; the two squares share the one multiplier.
//  The request that closes a group adds the root/divide engine, bit serial
//  on one subtractor: square root, compare, divide, done; the divide steps
//  drop out when the gain is 0 or saturates. Each result is then scaled on
//  the multiplier (SC_RE, SC_IM, SC_FIN) and waits in the output register,
//  where it holds while m_axis_tready is low.
//  s_axis_tready is high only when the sequencer is idle.
//  Reset clears sum, count, sequencer and the registers (threshold 0,
//  channels 1); the channel store holds no reset value.
//
module joint_channel_soft_threshold_top #(
    parameter int MAX_CHANNELS = jcst_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = jcst_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jcst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [jcst_pkg::THR_BITS-1:0]       cfg_data,
    // input channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [DATA_W-1:0]                   s_axis_tdata,  // re_in, im_in
    // output channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [DATA_W-1:0]                   m_axis_tdata,  // re_out, im_out
    output logic                                m_axis_tlast   // last_channel
);
    import jcst_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int SUM_W  = 2 * S + $clog2(MAX_CHANNELS);
    localparam int MAG_W  = (SUM_W + 1) / 2;
    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int MB_W   = (S > GAIN_BITS) ? S : GAIN_BITS;
    localparam int PROD_W = S + MB_W;

    function automatic logic [S-1:0] mag_of(input logic signed [S-1:0] x);
        logic signed [S-1:0] n;
        n = -x;
        return x[S-1] ? S'(n) : S'(x);
    endfunction

    jcst_state_t state_reg, state_next;

    logic [THR_BITS-1:0]  thr_reg,   thr_next;
    logic [CIU_BITS-1:0]  ciu_reg,   ciu_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    k_reg,     k_next;
    logic [SUM_W-1:0]     sum_reg,   sum_next;
    logic signed [S-1:0]  re_reg,    re_next;
    logic signed [S-1:0]  im_reg,    im_next;
    logic [PROD_W-1:0]    prod_reg,  prod_next;
    logic signed [S-1:0]  re_out_reg, re_out_next;
    logic signed [S-1:0]  im_out_reg, im_out_next;
    logic [2*S-1:0]       rd_word_reg;

    // channel store: {re, im}
    logic [2*S-1:0]       store_mem [MAX_CHANNELS];

    logic                 in_fire;
    logic signed [S-1:0]  s_re;
    logic signed [S-1:0]  s_im;
    logic signed [S-1:0]  rd_re;
    logic signed [S-1:0]  rd_im;
    logic [CNT_W-1:0]     group;
    logic                 finish;
    logic                 last_out;
    logic [SUM_W-1:0]     sum_acc;
    logic [S-1:0]         mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [S-1:0]         scaled;
    logic signed [S-1:0]  scaled_neg;
    logic                 rd_start;
    logic                 rd_done;
    logic [GAIN_BITS-1:0] gain;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign s_re      = s_axis_tdata[S-1:0];
    assign s_im      = s_axis_tdata[2*S-1:S];
    assign rd_re     = rd_word_reg[2*S-1:S];
    assign rd_im     = rd_word_reg[S-1:0];
    assign sum_acc   = sum_reg + SUM_W'(prod_reg);
    assign finish    = (count_reg >= group);
    assign last_out  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign scaled    = prod_reg[GAIN_BITS +: S];   // floor(|x| * gain / 2^16)
    assign scaled_neg = -$signed(scaled);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = DATA_W'({im_out_reg, re_out_reg});
    assign m_axis_tlast  = last_out;

    // group size: zero acts as one, oversize clamps to the store depth
    always_comb
    begin
        if (ciu_reg == '0)
            group = CNT_W'(1);
        else if (int'(ciu_reg) > MAX_CHANNELS)
            group = CNT_W'(MAX_CHANNELS);
        else
            group = CNT_W'(ciu_reg);
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_RE:
            begin
                mul_a = mag_of(re_reg);
                mul_b = MB_W'(mag_of(re_reg));
            end
            ST_SQ_IM:
            begin
                mul_a = mag_of(im_reg);
                mul_b = MB_W'(mag_of(im_reg));
            end
            ST_SC_RE:
            begin
                mul_a = mag_of(rd_re);
                mul_b = MB_W'(gain);
            end
            ST_SC_IM:
            begin
                mul_a = mag_of(rd_im);
                mul_b = MB_W'(gain);
            end
            default:
            begin
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_SQ_RE;
            ST_SQ_RE:
                state_next = ST_SQ_IM;
            ST_SQ_IM:
                state_next = ST_ACC;
            ST_ACC:
                state_next = finish ? ST_ROOT : ST_IDLE;
            ST_ROOT:
                if (rd_done)
                    state_next = ST_SC_RE;
            ST_SC_RE:
                state_next = ST_SC_IM;
            ST_SC_IM:
                state_next = ST_SC_FIN;
            ST_SC_FIN:
                state_next = ST_OUT;
            ST_OUT:
                if (m_axis_tready)
                    state_next = last_out ? ST_IDLE : ST_SC_RE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        thr_next    = thr_reg;
        ciu_next    = ciu_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        re_out_next = re_out_reg;
        im_out_next = im_out_reg;
        rd_start    = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_next = cfg_data;
                REG_CHANNELS:  ciu_next = cfg_data[CIU_BITS-1:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    re_next    = s_re;
                    im_next    = s_im;
                    count_next = count_reg + CNT_W'(1);
                end
            ST_SQ_IM:
                sum_next = sum_acc;        // re squared
            ST_ACC:
            begin
                // group complete: engine takes the full sum, running sum clears
                rd_start = finish;
                sum_next = finish ? '0 : sum_acc;
            end
            ST_ROOT:
                if (rd_done)
                    k_next = '0;
            ST_SC_IM:
                re_out_next = rd_re[S-1] ? scaled_neg : $signed(scaled);
            ST_SC_FIN:
                im_out_next = rd_im[S-1] ? scaled_neg : $signed(scaled);
            ST_OUT:
                if (m_axis_tready)
                begin
                    if (last_out)
                        count_next = '0;
                    else
                        k_next = k_reg + 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    jcst_root_div #(
        .SUM_W (SUM_W),
        .MAG_W (MAG_W)
    ) u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rd_start),
        .sum       (sum_acc),
        .threshold (thr_reg),
        .done      (rd_done),
        .gain      (gain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg   <= '0;
            ciu_reg   <= CIU_RESET;
            count_reg <= '0;
            k_reg     <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            ciu_reg   <= ciu_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg     <= re_next;
        im_reg     <= im_next;
        prod_reg   <= prod_next;
        re_out_reg <= re_out_next;
        im_out_reg <= im_out_next;
    end

    // store write on accept, registered read at the next channel index
    always_ff @(posedge clk)
    begin
        if (in_fire)
            store_mem[count_reg[ADDR_W-1:0]] <= {s_re, s_im};
        rd_word_reg <= store_mem[k_next];
    end

endmodule

### hdl/jcst_root_div.sv
// ----------------------------------------------------------------------------
// jcst_root_div
// Integer square root of the group energy, then the Q0.16 shrink gain,
// both on one shared trial subtractor, one result bit per cycle.
// ----------------------------------------------------------------------------
module jcst_root_div #(
    parameter int SUM_W = 35,
    parameter int MAG_W = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              sum,
    input  logic [jcst_pkg::THR_BITS-1:0] threshold,
    output logic                          done,
    output logic [jcst_pkg::GAIN_BITS-1:0] gain
);
    import jcst_pkg::*;

    localparam int RAD_W    = 2 * MAG_W;
    localparam int SUB_W    = (MAG_W + 2 > THR_BITS) ? MAG_W + 2 : THR_BITS;
    localparam int MAX_ITER = (MAG_W > GAIN_BITS) ? MAG_W : GAIN_BITS;
    localparam int ITER_W   = $clog2(MAX_ITER);

    jcst_rd_state_t state_reg, state_next;

    logic [RAD_W-1:0]     rad_reg,  rad_next;
    logic [SUB_W-1:0]     rem_reg,  rem_next;
    logic [MAG_W-1:0]     root_reg, root_next;
    logic [GAIN_BITS-1:0] q_reg,    q_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;

    // shared trial subtractor
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
    logic [SUB_W:0]   sub_full;
    logic             borrow;
    logic             last_iter;

    assign sub_full  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow    = sub_full[SUB_W];
    assign last_iter = (iter_reg == '0);

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            RD_ROOT:
            begin
                sub_a = SUB_W'({rem_reg[MAG_W-1:0], rad_reg[RAD_W-1 -: 2]});
                sub_b = SUB_W'({root_reg, 2'b01});
            end
            RD_CMP:
            begin
                sub_a = SUB_W'(root_reg);
                sub_b = SUB_W'(threshold);
            end
            RD_DIV:
            begin
                sub_a = SUB_W'({rem_reg[MAG_W-1:0], 1'b0});
                sub_b = SUB_W'(root_reg);
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RD_IDLE:
                if (start)
                    state_next = RD_ROOT;
            RD_ROOT:
                if (last_iter)
                    state_next = RD_CMP;
            RD_CMP:
                if (root_reg == '0 || borrow || sub_full[SUB_W-1:0] == '0
                    || threshold == '0)
                    state_next = RD_DONE;
                else
                    state_next = RD_DIV;
            RD_DIV:
                if (last_iter)
                    state_next = RD_DONE;
            RD_DONE:
                state_next = RD_IDLE;
            default:
                state_next = RD_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        q_next    = q_reg;
        iter_next = iter_reg;
        done      = 1'b0;
        case (state_reg)
            RD_IDLE:
                if (start)
                begin
                    rad_next  = RAD_W'(sum);
                    rem_next  = '0;
                    root_next = '0;
                    iter_next = ITER_W'(MAG_W - 1);
                end
            RD_ROOT:
            begin
                rem_next  = borrow ? sub_a : sub_full[SUB_W-1:0];
                root_next = {root_reg[MAG_W-2:0], ~borrow};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                iter_next = iter_reg - 1'b1;
            end
            RD_CMP:
            begin
                // zero magnitude or magnitude at or below threshold: gain 0
                if (root_reg == '0 || borrow || sub_full[SUB_W-1:0] == '0)
                    q_next = '0;
                else if (threshold == '0)
                    q_next = '1;            // unity gain saturates
                else
                begin
                    q_next    = '0;
                    rem_next  = sub_full[SUB_W-1:0];
                    iter_next = ITER_W'(GAIN_BITS - 1);
                end
            end
            RD_DIV:
            begin
                rem_next  = borrow ? sub_a : sub_full[SUB_W-1:0];
                q_next    = {q_reg[GAIN_BITS-2:0], ~borrow};
                iter_next = iter_reg - 1'b1;
            end
            RD_DONE:
                done = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign gain = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RD_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        q_reg    <= q_next;
    end

endmodule

### hdl/jcst_checker.sv
// ----------------------------------------------------------------------------
// jcst_checker
// Port-level checks on request sequencing of the soft threshold block.
// ----------------------------------------------------------------------------
module jcst_checker #(
    parameter int DATA_W = 32
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic              m_axis_tlast,
    input logic [DATA_W-1:0] m_axis_tdata
);

    // never takes input while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after accept");

    // group not finished until tlast leaves
    a_group_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input ready mid-group");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind joint_channel_soft_threshold_top jcst_checker #(
    .DATA_W (DATA_W)
) u_jcst_checker (.*);
